// ----- hdl/tcr_pkg.sv -----
// ----------------------------------------------------------------------------
// tcr_pkg
// Types, state codes and flag masks shared by the connection responder.
// ----------------------------------------------------------------------------
package tcr_pkg;

  // Width of the initial sequence register
  localparam int ISN_W   = 11;
  localparam int STATE_W = 3;

  // Connection state codes
  localparam logic [STATE_W-1:0] ST_CLOSED      = 3'd0;
  localparam logic [STATE_W-1:0] ST_HANDSHAKE   = 3'd1;
  localparam logic [STATE_W-1:0] ST_ESTABLISHED = 3'd2;
  localparam logic [STATE_W-1:0] ST_FIN_SENT    = 3'd3;
  localparam logic [STATE_W-1:0] ST_FIN_ACKED   = 3'd4;
  localparam logic [STATE_W-1:0] ST_CLOSING     = 3'd5;

  // Header flag masks: urg ack psh rst syn fin
  localparam logic [5:0] FLAG_URG = 6'h20;
  localparam logic [5:0] FLAG_ACK = 6'h10;
  localparam logic [5:0] FLAG_PSH = 6'h08;
  localparam logic [5:0] FLAG_RST = 6'h04;
  localparam logic [5:0] FLAG_SYN = 6'h02;
  localparam logic [5:0] FLAG_FIN = 6'h01;

  // Received header item
  typedef struct packed {
    logic [15:0] rx_src_port;
    logic [15:0] rx_dst_port;
    logic [31:0] rx_seq;
    logic [31:0] rx_ack;
    logic [3:0]  rx_data_offset;
    logic [5:0]  rx_reserved;
    logic [5:0]  rx_flags;
    logic [15:0] rx_window;
    logic [15:0] rx_checksum;
    logic [15:0] rx_urgent;
    logic        source_short;
  } rx_item_t;

  // Response header item
  typedef struct packed {
    logic [15:0]        tx_src_port;
    logic [15:0]        tx_dst_port;
    logic [31:0]        tx_seq;
    logic [31:0]        tx_ack;
    logic [3:0]         tx_data_offset;
    logic [5:0]         tx_reserved;
    logic [5:0]         tx_flags;
    logic [15:0]        tx_window;
    logic [15:0]        tx_checksum;
    logic [15:0]        tx_urgent;
    logic               carries_chunk;
    logic [STATE_W-1:0] new_state;
  } tx_item_t;

  // Decode status handed from the decoder to the top level
  typedef struct packed {
    logic               emit;
    logic [STATE_W-1:0] state_next;
  } dec_status_t;

endpackage

// ----- hdl/tcr_if.sv -----
// ----------------------------------------------------------------------------
// tcr_if
// Valid/ready channels of the connection responder: header in, header out,
// and the configuration write channel.
// ----------------------------------------------------------------------------
interface tcr_rx_if import tcr_pkg::*; ();
  logic     valid;
  logic     ready;
  rx_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface tcr_tx_if import tcr_pkg::*; ();
  logic     valid;
  logic     ready;
  tx_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface tcr_cfg_if import tcr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ISN_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/tcr_decode.sv -----
// ----------------------------------------------------------------------------
// tcr_decode
// Flag decode for one received header: builds the response header, decides
// whether a response goes out and works out the next connection state.
// ----------------------------------------------------------------------------
module tcr_decode
  import tcr_pkg::*;
(
  input  logic [STATE_W-1:0] state,
  input  logic [ISN_W-1:0]   initial_sequence,
  input  rx_item_t           rx_item,
  output tx_item_t           tx_item,
  output dec_status_t        status
);

  logic               syn;
  logic               ack;
  logic               fin;
  logic               live;
  logic               inc;
  logic               chunk;
  logic [5:0]         tflags;
  logic [31:0]        tseq;
  logic [31:0]        seq_inc;
  logic [STATE_W-1:0] next;
  logic [STATE_W-1:0] next_final;

  assign syn     = (rx_item.rx_flags & FLAG_SYN) != 6'd0;
  assign ack     = (rx_item.rx_flags & FLAG_ACK) != 6'd0;
  assign fin     = (rx_item.rx_flags & FLAG_FIN) != 6'd0;
  // Closed and the unused codes swallow every header
  assign live    = (state != ST_CLOSED) && (state <= ST_CLOSING);
  assign seq_inc = rx_item.rx_seq + 32'd1;

  // Apply the flag rules in priority order
  always_comb begin
    tflags = rx_item.rx_flags;
    tseq   = rx_item.rx_ack;
    inc    = syn;
    next   = state;
    if (syn && ack) begin
      tflags = rx_item.rx_flags & ~FLAG_SYN;
    end else if (syn) begin
      tflags = rx_item.rx_flags | FLAG_ACK;
      tseq   = {{(32-ISN_W){1'b0}}, initial_sequence};
    end else if (fin && ((state == ST_FIN_ACKED) || ((state == ST_FIN_SENT) && ack))) begin
      tflags = FLAG_ACK;
      inc    = 1'b1;
      next   = ST_CLOSED;
    end else if (ack && (state == ST_HANDSHAKE)) begin
      next = ST_ESTABLISHED;
    end else if (ack && (state == ST_CLOSING)) begin
      tflags = FLAG_FIN;
      next   = ST_FIN_SENT;
    end else if (ack && (state == ST_FIN_SENT)) begin
      next = ST_FIN_ACKED;
    end
  end

  // Send a chunk while established; a short chunk starts the close
  assign chunk      = (next == ST_ESTABLISHED);
  assign next_final = (chunk && rx_item.source_short) ? ST_CLOSING : next;

  assign status.emit       = live && (next <= ST_FIN_SENT);
  assign status.state_next = live ? next_final : state;

  // Assemble the response header
  assign tx_item.tx_src_port    = rx_item.rx_dst_port;
  assign tx_item.tx_dst_port    = rx_item.rx_src_port;
  assign tx_item.tx_seq         = tseq;
  assign tx_item.tx_ack         = inc ? seq_inc : rx_item.rx_seq;
  assign tx_item.tx_data_offset = rx_item.rx_data_offset;
  assign tx_item.tx_reserved    = rx_item.rx_reserved;
  assign tx_item.tx_flags       = tflags;
  assign tx_item.tx_window      = rx_item.rx_window;
  assign tx_item.tx_checksum    = rx_item.rx_checksum;
  assign tx_item.tx_urgent      = rx_item.rx_urgent;
  assign tx_item.carries_chunk  = chunk;
  assign tx_item.new_state      = next_final;

endmodule

// ----- hdl/tcp_connection_responder_core.sv -----
// ----------------------------------------------------------------------------
// tcp_connection_responder_core
// Server side of a simplified TCP-like exchange with one connection.
// ----------------------------------------------------------------------------
// Takes one received header per cycle on rx while the result register is
// empty or being drained, and answers with at most one response header on
// tx in the cycle after acceptance. The connection state register feeds the
// flag decode directly, so each header sees the state left by the one before
// it. The result register alone parts the two sides. The initial sequence
// for a bare SYN is written through cfg only while the block is idle, a rule
// for the user that the block does not enforce; cfg is always ready.
// ----------------------------------------------------------------------------
module tcp_connection_responder_core
  import tcr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  tcr_rx_if.sink    rx,
  tcr_tx_if.source  tx,
  tcr_cfg_if.sink   cfg
);

  logic [STATE_W-1:0] state;
  logic [ISN_W-1:0]   initial_sequence;
  logic               out_valid;
  tx_item_t           out_item;
  tx_item_t           dec_item;
  dec_status_t        dec_status;
  logic               rx_acc;

  tcr_decode u_decode (
    .state            (state),
    .initial_sequence (initial_sequence),
    .rx_item          (rx.item),
    .tx_item          (dec_item),
    .status           (dec_status)
  );

  // Take a header whenever the result register is free or draining
  assign rx.ready = !out_valid || tx.ready;
  assign rx_acc   = rx.valid && rx.ready;
  assign cfg.ready = 1'b1;

  // Hold the configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_sequence <= '0;
    end else if (cfg.valid) begin
      initial_sequence <= cfg.data;
    end
  end

  // Advance the connection state on every accepted header
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HANDSHAKE;
    end else if (rx_acc) begin
      state <= dec_status.state_next;
    end
  end

  // Load or drain the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rx_acc) begin
      out_valid <= dec_status.emit;
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_acc && dec_status.emit) begin
      out_item <= dec_item;
    end
  end

  assign tx.valid = out_valid;
  assign tx.item  = out_item;

  // A closed connection never reopens
  a_closed_sticky: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLOSED) |=> (state == ST_CLOSED))
    else $error("connection left the closed state");

  // A loaded response reports the state the register now holds
  a_state_matches: assert property (@(posedge clk) disable iff (rst)
    (rx_acc && dec_status.emit) |=> (tx.valid && (tx.item.new_state == state)))
    else $error("response state differs from connection state");

  // A chunk only goes out in the established or closing state
  a_chunk_state: assert property (@(posedge clk) disable iff (rst)
    (tx.valid && tx.item.carries_chunk) |->
      ((tx.item.new_state == ST_ESTABLISHED) || (tx.item.new_state == ST_CLOSING)))
    else $error("data chunk outside established state");

  // Nothing is emitted while closed
  a_closed_silent: assert property (@(posedge clk) disable iff (rst)
    (rx_acc && (state == ST_CLOSED)) |=> !tx.valid)
    else $error("response emitted in closed state");

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the TCP connection responder core.
// Headers go in on rx in random bursts and responses are taken from tx under a
// changing stall pattern. A bench-side copy of the connection state predicts
// each response, which is compared with what the core gives. The run walks
// one connection from handshake through established, closing and the FIN
// exchange to closed, and rewrites the initial sequence between phases.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tcr_pkg::*;

  localparam int unsigned HALF_PERIOD  = 10;
  localparam int unsigned RESET_CYCLES = 9;
  localparam int unsigned SETTLE_WAIT  = 6;
  localparam int unsigned TAIL_WAIT    = 40;
  localparam int unsigned DRAIN_LIMIT  = 4000;
  localparam int unsigned RUN_LIMIT    = 5_000_000;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef enum int {FILL_ZERO, FILL_ONES, FILL_RANDOM} fill_t;
  typedef enum int {TAKE_FREE, TAKE_COIN, TAKE_SPARSE, TAKE_STALLS} take_mode_t;

  logic clk;
  logic rst;

  tcr_rx_if  rx_if ();
  tcr_tx_if  tx_if ();
  tcr_cfg_if cfg_if ();

  tcp_connection_responder_core u_dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .tx  (tx_if),
    .cfg (cfg_if)
  );

  // Bench copy of the connection and the register
  logic [STATE_W-1:0] link_state;
  logic [ISN_W-1:0]   isn_value;
  tx_item_t           pending_responses[$];
  int unsigned        mismatches;
  int unsigned        burst_left;

  // Clock
  initial begin
    clk = 1'b0;
    forever #(HALF_PERIOD) clk = ~clk;
  end

  // Give up after a generous time
  initial begin
    #(RUN_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // Biased value of a field: zero, all ones or anything
  function automatic logic [31:0] pick_bits(input int width);
    logic [63:0] mask;
    mask = (64'd1 << width) - 64'd1;
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return mask[31:0];
      default: return $urandom & mask[31:0];
    endcase
  endfunction

  function automatic rx_item_t build_header(input fill_t fill, input logic [5:0] flags,
                                            input logic short_bit);
    rx_item_t h;
    case (fill)
      FILL_ZERO: h = '0;
      FILL_ONES: h = '1;
      default: begin
        h.rx_src_port    = 16'(pick_bits(16));
        h.rx_dst_port    = 16'(pick_bits(16));
        h.rx_seq         = pick_bits(32);
        h.rx_ack         = pick_bits(32);
        h.rx_data_offset = 4'(pick_bits(4));
        h.rx_reserved    = 6'(pick_bits(6));
        h.rx_window      = 16'(pick_bits(16));
        h.rx_checksum    = 16'(pick_bits(16));
        h.rx_urgent      = 16'(pick_bits(16));
      end
    endcase
    h.rx_flags     = flags;
    h.source_short = short_bit;
    return h;
  endfunction

  // Work out the response to one header and advance the connection
  function automatic bit predict_response(input rx_item_t h, output tx_item_t r);
    logic               syn, ack, fin, chunk;
    logic [31:0]        tseq, tack;
    logic [5:0]         tflags;
    logic [STATE_W-1:0] nxt;
    r = '0;
    if (link_state == ST_CLOSED || link_state > ST_CLOSING) return 1'b0;
    syn    = (h.rx_flags & FLAG_SYN) != 6'd0;
    ack    = (h.rx_flags & FLAG_ACK) != 6'd0;
    fin    = (h.rx_flags & FLAG_FIN) != 6'd0;
    tseq   = h.rx_ack;
    tack   = syn ? h.rx_seq + 32'd1 : h.rx_seq;
    tflags = h.rx_flags;
    nxt    = link_state;
    chunk  = 1'b0;
    if (syn && ack) begin
      tflags = h.rx_flags & ~FLAG_SYN;
    end else if (syn) begin
      tflags = h.rx_flags | FLAG_ACK;
      tseq   = {{(32-ISN_W){1'b0}}, isn_value};
    end else if (fin && (link_state == ST_FIN_ACKED || (link_state == ST_FIN_SENT && ack))) begin
      tflags = FLAG_ACK;
      tack   = h.rx_seq + 32'd1;
      nxt    = ST_CLOSED;
    end else if (ack && link_state == ST_HANDSHAKE) begin
      nxt = ST_ESTABLISHED;
    end else if (ack && link_state == ST_CLOSING) begin
      tflags = FLAG_FIN;
      nxt    = ST_FIN_SENT;
    end else if (ack && link_state == ST_FIN_SENT) begin
      nxt = ST_FIN_ACKED;
    end
    link_state = nxt;
    if (nxt > ST_FIN_SENT) return 1'b0;
    // A chunk goes out with every established response; a short one ends data
    if (nxt == ST_ESTABLISHED) begin
      chunk = 1'b1;
      if (h.source_short) nxt = ST_CLOSING;
      link_state = nxt;
    end
    r.tx_src_port    = h.rx_dst_port;
    r.tx_dst_port    = h.rx_src_port;
    r.tx_seq         = tseq;
    r.tx_ack         = tack;
    r.tx_data_offset = h.rx_data_offset;
    r.tx_reserved    = h.rx_reserved;
    r.tx_flags       = tflags;
    r.tx_window      = h.rx_window;
    r.tx_checksum    = h.rx_checksum;
    r.tx_urgent      = h.rx_urgent;
    r.carries_chunk  = chunk;
    r.new_state      = nxt;
    return 1'b1;
  endfunction

  function automatic string describe(input tx_item_t r);
    return $sformatf({"src %h dst %h seq %h ack %h off %h res %h flags %h win %h ",
                      "sum %h urg %h chunk %b state %0d"},
                     r.tx_src_port, r.tx_dst_port, r.tx_seq, r.tx_ack, r.tx_data_offset,
                     r.tx_reserved, r.tx_flags, r.tx_window, r.tx_checksum, r.tx_urgent,
                     r.carries_chunk, r.new_state);
  endfunction

  // Send one header, with a random gap at the start of each burst
  task automatic send_header(input rx_item_t h);
    tx_item_t resp;
    int       gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        rx_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    rx_if.valid <= 1'b1;
    rx_if.item  <= h;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    if (predict_response(h, resp)) pending_responses.push_back(resp);
  endtask

  // Random headers shaped so that the connection holds its current state
  task automatic send_random_headers(input int count);
    rx_item_t h;
    repeat (count) begin
      h = build_header(FILL_RANDOM, 6'($urandom), 1'($urandom));
      case (link_state)
        ST_HANDSHAKE, ST_CLOSING, ST_FIN_SENT: begin
          if ((h.rx_flags & FLAG_ACK) != 6'd0 && (h.rx_flags & FLAG_SYN) == 6'd0)
            h.rx_flags = ($urandom_range(0, 1) != 0) ? (h.rx_flags | FLAG_SYN)
                                                     : (h.rx_flags & ~FLAG_ACK);
        end
        ST_ESTABLISHED: h.source_short = 1'b0;
        ST_FIN_ACKED:   h.rx_flags = h.rx_flags & ~FLAG_FIN;
        default: ;
      endcase
      send_header(h);
    end
  endtask

  // Hold off until every response is in and the core has gone quiet
  task automatic settle_block();
    rx_if.valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_isn(input logic [ISN_W-1:0] value);
    settle_block();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    isn_value = value;
    cfg_if.valid <= 1'b0;
  endtask

  // Handshake state with the register at its reset value
  task automatic test_handshake_directed();
    send_header(build_header(FILL_ONES, FLAG_SYN, 1'b0));
    send_header(build_header(FILL_ZERO, FLAG_SYN, 1'b0));
    send_header(build_header(FILL_ONES, FLAG_SYN | FLAG_ACK, 1'b0));
    send_header(build_header(FILL_ZERO, FLAG_FIN, 1'b0));
    send_header(build_header(FILL_ONES, FLAG_RST | FLAG_URG | FLAG_PSH, 1'b1));
    send_header(build_header(FILL_RANDOM, 6'h00, 1'b1));
    send_header(build_header(FILL_RANDOM, FLAG_SYN | FLAG_FIN | FLAG_RST, 1'b0));
    send_header(build_header(FILL_RANDOM, 6'h3F, 1'b1));
  endtask

  // Bare SYN answered with the largest, the nominal top and zero sequence
  task automatic test_isn_extremes();
    write_isn(11'd2047);
    send_header(build_header(FILL_RANDOM, FLAG_SYN, 1'b0));
    write_isn(11'd1999);
    send_header(build_header(FILL_RANDOM, FLAG_SYN | FLAG_URG, 1'b1));
    write_isn(11'd0);
    send_header(build_header(FILL_ONES, FLAG_SYN, 1'b0));
  endtask

  task automatic test_handshake_random();
    write_isn(11'($urandom_range(0, 2047)));
    send_random_headers(150);
  endtask

  // Move to established, then each kind of header while data flows
  task automatic test_establish();
    send_header(build_header(FILL_ONES, FLAG_ACK | FLAG_PSH, 1'b0));
    send_header(build_header(FILL_ONES, FLAG_SYN, 1'b0));
    send_header(build_header(FILL_ZERO, FLAG_SYN | FLAG_ACK, 1'b0));
    send_header(build_header(FILL_RANDOM, FLAG_FIN | FLAG_ACK, 1'b0));
    send_header(build_header(FILL_ZERO, 6'h00, 1'b0));
    send_header(build_header(FILL_ONES, FLAG_RST, 1'b0));
  endtask

  task automatic test_established_random();
    write_isn(11'($urandom_range(0, 2047)));
    send_random_headers(200);
    write_isn(11'd2047);
    send_random_headers(200);
    write_isn(11'($urandom_range(0, 1999)));
    send_random_headers(200);
  endtask

  // Short chunk, FIN exchange, then headers that a closed link must drop
  task automatic test_close_sequence();
    send_header(build_header(FILL_RANDOM, 6'($urandom), 1'b1));
    send_random_headers(60);
    send_header(build_header(FILL_RANDOM,
                             FLAG_ACK | 6'($urandom & (FLAG_URG | FLAG_PSH | FLAG_RST | FLAG_FIN)),
                             1'($urandom)));
    send_random_headers(150);
    if ($urandom_range(0, 1) != 0) begin
      send_header(build_header(FILL_RANDOM,
                               FLAG_FIN | FLAG_ACK | 6'($urandom & (FLAG_URG | FLAG_PSH | FLAG_RST)),
                               1'($urandom)));
    end else begin
      send_header(build_header(FILL_RANDOM,
                               FLAG_ACK | 6'($urandom & (FLAG_URG | FLAG_PSH | FLAG_RST)),
                               1'($urandom)));
      send_random_headers(40);
      send_header(build_header(FILL_RANDOM,
                               FLAG_FIN | 6'($urandom & (FLAG_URG | FLAG_PSH | FLAG_RST | FLAG_ACK)),
                               1'($urandom)));
    end
    write_isn(11'($urandom_range(0, 2047)));
    send_random_headers(40);
  endtask

  // Response side: stall on a pattern that changes every so often
  initial begin
    take_mode_t  mode;
    int unsigned span;
    int unsigned tick;
    int unsigned stall_left;
    tx_if.ready <= 1'b0;
    tick       = 0;
    stall_left = 0;
    forever begin
      mode = take_mode_t'($urandom_range(0, 3));
      span = $urandom_range(30, 200);
      repeat (span) begin
        @(posedge clk);
        tick++;
        case (mode)
          TAKE_FREE:   tx_if.ready <= 1'b1;
          TAKE_COIN:   tx_if.ready <= 1'($urandom);
          TAKE_SPARSE: tx_if.ready <= (tick % 4 == 0);
          default: begin
            if (stall_left > 0) begin
              stall_left--;
              tx_if.ready <= 1'b0;
            end else begin
              tx_if.ready <= 1'b1;
              if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(4, 12);
            end
          end
        endcase
      end
    end
  end

  // Compare each response taken with the oldest one predicted
  initial begin
    tx_item_t want;
    forever begin
      @(posedge clk);
      if (!rst && tx_if.valid && tx_if.ready) begin
        if (pending_responses.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected response: %s", describe(tx_if.item));
        end else begin
          want = pending_responses.pop_front();
          if (tx_if.item !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("response differs\n  expected %s\n  actual   %s",
                       describe(want), describe(tx_if.item));
          end
        end
      end
    end
  end

  // Reset, run the tests in turn, then drain and report
  initial begin
    int unsigned waited;
    rst          <= 1'b1;
    rx_if.valid  <= 1'b0;
    rx_if.item   <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    link_state   = ST_HANDSHAKE;
    isn_value    = '0;
    mismatches   = 0;
    burst_left   = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_handshake_directed();
    test_isn_extremes();
    test_handshake_random();
    test_establish();
    test_established_random();
    test_close_sequence();

    rx_if.valid <= 1'b0;
    waited = 0;
    while (pending_responses.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatches == 0 && pending_responses.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
